// ----- hdl/assert_macros.svh -----
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// cond must never be true at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hdl/imu_unpk_pkg.sv -----
package imu_unpk_pkg;

  localparam int unsigned AddrW    = 5;
  localparam int unsigned InDepth  = 2;
  localparam int unsigned InPtrW   = $clog2(InDepth);
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  localparam logic [7:0]  START_MARK = 8'h3A;
  localparam logic [15:0] CMD_ACK    = 16'h0000;
  localparam logic [15:0] CMD_NACK   = 16'h0001;
  localparam logic [15:0] CMD_DATA   = 16'h0009;
  localparam logic [4:0]  Q_TSTAMP   = 5'd0;
  localparam logic [4:0]  Q_TEMP     = 5'd29;

  // register index (paddr[4:2])
  typedef enum logic [2:0] {
    REG_DEV_ID    = 3'd0,
    REG_DECODE_EN = 3'd1,
    REG_PREC32    = 3'd2,
    REG_RADIANS   = 3'd3,
    REG_MASK      = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_LINK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FMT_U32   = 2'd0,
    FMT_I16   = 2'd1,
    FMT_F32   = 2'd2
  } fmt_e;

  typedef enum logic [2:0] {
    ST_REJECTED = 3'd0,
    ST_ACK      = 3'd1,
    ST_NACK     = 3'd2,
    ST_DATA     = 3'd3,
    ST_OTHER    = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] dev_id;
    logic        decode_en;
    logic        prec32;
    logic        radians;
    logic [9:0]  mask;
  } cfg_t;

  // classified input item
  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  quantity;
    logic [31:0] value_bits;
    fmt_e        value_format;
    logic [2:0]  decimal_places;
    status_e     frame_status;
    logic        reply_flag;
    logic        last;
  } res_t;

endpackage

// ----- hdl/imu_unpk_front.sv -----
module imu_unpk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_end_i,
  output logic                item_valid_o,
  input  logic                item_pop_i,
  output imu_unpk_pkg::item_t item_o
);

  imu_unpk_pkg::item_t mem_q [imu_unpk_pkg::InDepth];
  logic [imu_unpk_pkg::InPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [imu_unpk_pkg::InPtrW:0]   cnt_q, cnt_d;
  logic push;
  imu_unpk_pkg::item_t new_item;

  assign in_ready_o   = (cnt_q != (imu_unpk_pkg::InPtrW + 1)'(imu_unpk_pkg::InDepth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign push         = in_valid_i && in_ready_o;

  always_comb begin
    new_item.is_tick   = cmd_i;
    new_item.rx_byte   = cmd_i ? 8'h00 : rx_byte_i;
    new_item.frame_end = !cmd_i && frame_end_i;
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = item_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{imu_unpk_pkg::InPtrW{1'b0}}, push}
                  - {{imu_unpk_pkg::InPtrW{1'b0}}, item_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= new_item;
    end
  end

endmodule

// ----- hdl/imu_unpk_back.sv -----
`include "assert_macros.svh"

module imu_unpk_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imu_unpk_pkg::cfg_t  cfg_i,
  input  logic                item_valid_i,
  input  imu_unpk_pkg::item_t item_i,
  input  logic                room_i,
  output logic                item_pop_o,
  output logic [1:0]          res_n_o,
  output imu_unpk_pkg::res_t  res0_o,
  output imu_unpk_pkg::res_t  res1_o
);

  logic [7:0]  pos_q, pos_d;
  logic [31:0] asm_q, asm_d;
  logic [7:0]  id_lo_q, id_lo_d;
  logic [15:0] cmd_q, cmd_d;
  logic        rej_q, rej_d;
  logic [4:0]  qidx_q, qidx_d;
  logic [31:0] link_q, link_d;
  logic        reply_q, reply_d;
  logic        dec_q, dec_d;
  logic [1:0]  ecnt_q, ecnt_d;

  logic [29:1] present;
  logic [4:0]  nxt_slot;
  logic        next_found;

  function automatic logic [3:0] grp_of(input logic [4:0] q);
    logic [3:0] g;
    if (q >= 5'd29)      g = 4'd9;
    else if (q >= 5'd26) g = 4'd8;
    else if (q >= 5'd23) g = 4'd7;
    else if (q >= 5'd19) g = 4'd6;
    else if (q >= 5'd16) g = 4'd5;
    else if (q >= 5'd13) g = 4'd4;
    else if (q >= 5'd10) g = 4'd3;
    else if (q >= 5'd7)  g = 4'd2;
    else if (q >= 5'd4)  g = 4'd1;
    else                 g = 4'd0;
    return g;
  endfunction

  function automatic logic [2:0] decimals_of(input logic [4:0] q, input logic rad);
    logic [2:0] d;
    unique case (grp_of(q))
      4'd0, 4'd1, 4'd8: d = 3'd3;
      4'd2, 4'd3, 4'd4: d = rad ? 3'd2 : 3'd1;
      4'd6:             d = 3'd4;
      4'd7:             d = rad ? 3'd4 : 3'd2;
      default:          d = 3'd2;
    endcase
    return d;
  endfunction

  // slots present in the payload; the temperature slot is always there in int16 mode
  always_comb begin
    for (int k = 1; k <= 29; k++) begin
      present[k] = cfg_i.mask[grp_of(5'(k))];
    end
    present[29] = cfg_i.mask[9] || !cfg_i.prec32;
  end

  always_comb begin
    nxt_slot   = '0;
    next_found = 1'b0;
    for (int k = 29; k >= 1; k--) begin
      if (present[k] && (5'(k) > qidx_q)) begin
        nxt_slot   = 5'(k);
        next_found = 1'b1;
      end
    end
  end

  assign item_pop_o = item_valid_i && room_i;

  always_comb begin
    logic [7:0]  b;
    logic        wide;
    logic        done;
    logic [31:0] full;
    logic [31:0] sx;
    imu_unpk_pkg::status_e st;
    imu_unpk_pkg::res_t    stat;

    b       = item_i.rx_byte;
    pos_d   = pos_q;
    asm_d   = asm_q;
    id_lo_d = id_lo_q;
    cmd_d   = cmd_q;
    rej_d   = rej_q;
    qidx_d  = qidx_q;
    link_d  = link_q;
    reply_d = reply_q;
    dec_d   = dec_q;
    ecnt_d  = ecnt_q;
    res0_o  = '0;
    res1_o  = '0;
    res_n_o = 2'd0;
    wide    = (qidx_q == imu_unpk_pkg::Q_TSTAMP) || cfg_i.prec32;
    done    = wide ? (ecnt_q == 2'd3) : (ecnt_q != 2'd0);
    full    = asm_q | ({24'h0, b} << {ecnt_q, 3'b000});
    sx      = {{16{full[15]}}, full[15:0]};
    st      = imu_unpk_pkg::ST_REJECTED;
    stat    = '0;

    if (item_i.is_tick) begin
      link_d            = link_q + 32'd1;
      res0_o.kind       = imu_unpk_pkg::KIND_LINK;
      res0_o.value_bits = link_d;
      res0_o.last       = 1'b1;
      res_n_o           = 2'd1;
    end else begin
      if (pos_q == 8'd0) begin
        rej_d = (b != imu_unpk_pkg::START_MARK);
      end else if (pos_q == 8'd1) begin
        id_lo_d = b;
      end else if (pos_q == 8'd2) begin
        if ({b, id_lo_q} != cfg_i.dev_id) rej_d = 1'b1;
      end else if (pos_q == 8'd3) begin
        cmd_d = {8'h00, b};
      end else if (pos_q == 8'd4) begin
        cmd_d = {b, cmd_q[7:0]};
        if (!rej_q) begin
          link_d = '0;
          if (cmd_d == imu_unpk_pkg::CMD_ACK) begin
            reply_d = 1'b1;
          end else if (cmd_d == imu_unpk_pkg::CMD_NACK) begin
            reply_d = 1'b0;
          end else if (cmd_d == imu_unpk_pkg::CMD_DATA && cfg_i.decode_en) begin
            dec_d  = 1'b1;
            qidx_d = '0;
            ecnt_d = '0;
            asm_d  = '0;
          end
        end
      end else if (pos_q >= 8'd7 && dec_q) begin
        if (done) begin
          if (qidx_q == imu_unpk_pkg::Q_TSTAMP) begin
            res0_o.kind       = imu_unpk_pkg::KIND_VALUE;
            res0_o.value_bits = full;
            res0_o.last       = 1'b1;
            res_n_o           = 2'd1;
          end else if (cfg_i.prec32) begin
            res0_o.kind         = imu_unpk_pkg::KIND_VALUE;
            res0_o.quantity     = qidx_q;
            res0_o.value_bits   = full;
            res0_o.value_format = imu_unpk_pkg::FMT_F32;
            res0_o.last         = 1'b1;
            res_n_o             = 2'd1;
          end else if (qidx_q != imu_unpk_pkg::Q_TEMP || cfg_i.mask[9]) begin
            res0_o.kind           = imu_unpk_pkg::KIND_VALUE;
            res0_o.quantity       = qidx_q;
            res0_o.value_bits     = sx;
            res0_o.value_format   = imu_unpk_pkg::FMT_I16;
            res0_o.decimal_places = decimals_of(qidx_q, cfg_i.radians);
            res0_o.last           = 1'b1;
            res_n_o               = 2'd1;
          end
          asm_d  = '0;
          ecnt_d = '0;
          if (next_found) qidx_d = nxt_slot;
          else            dec_d  = 1'b0;
        end else begin
          asm_d  = full;
          ecnt_d = ecnt_q + 2'd1;
        end
      end

      if (pos_q != 8'hFF) pos_d = pos_q + 8'd1;

      if (item_i.frame_end) begin
        if (rej_d || pos_q < 8'd4)                  st = imu_unpk_pkg::ST_REJECTED;
        else if (cmd_d == imu_unpk_pkg::CMD_ACK)    st = imu_unpk_pkg::ST_ACK;
        else if (cmd_d == imu_unpk_pkg::CMD_NACK)   st = imu_unpk_pkg::ST_NACK;
        else if (cmd_d == imu_unpk_pkg::CMD_DATA)   st = imu_unpk_pkg::ST_DATA;
        else                                        st = imu_unpk_pkg::ST_OTHER;
        stat.kind         = imu_unpk_pkg::KIND_STATUS;
        stat.frame_status = st;
        stat.reply_flag   = reply_d;
        stat.last         = 1'b1;
        if (res_n_o == 2'd0) begin
          res0_o  = stat;
          res_n_o = 2'd1;
        end else begin
          res0_o.last = 1'b0;
          res1_o      = stat;
          res_n_o     = 2'd2;
        end
        // back to the start of a frame
        pos_d   = '0;
        asm_d   = '0;
        id_lo_d = '0;
        cmd_d   = '0;
        rej_d   = 1'b0;
        qidx_d  = '0;
        dec_d   = 1'b0;
        ecnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      asm_q   <= '0;
      id_lo_q <= '0;
      cmd_q   <= '0;
      rej_q   <= 1'b0;
      qidx_q  <= '0;
      link_q  <= '0;
      reply_q <= 1'b0;
      dec_q   <= 1'b0;
      ecnt_q  <= '0;
    end else if (item_pop_o) begin
      pos_q   <= pos_d;
      asm_q   <= asm_d;
      id_lo_q <= id_lo_d;
      cmd_q   <= cmd_d;
      rej_q   <= rej_d;
      qidx_q  <= qidx_d;
      link_q  <= link_d;
      reply_q <= reply_d;
      dec_q   <= dec_d;
      ecnt_q  <= ecnt_d;
    end
  end

  `ASSERT_CLK(a_dec_after_hdr, dec_q |-> (pos_q >= 8'd5), "decode active inside frame header")
  `ASSERT_CLK(a_ecnt_idle, !dec_q |-> (ecnt_q == 2'd0), "partial element while not decoding")
  `ASSERT_NEVER(a_qidx_range, qidx_q > imu_unpk_pkg::Q_TEMP, "quantity index out of range")

endmodule

// ----- hdl/imu_unpk_outq.sv -----
`include "assert_macros.svh"

module imu_unpk_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_en_i,
  input  logic [1:0]         push_n_i,
  input  imu_unpk_pkg::res_t res0_i,
  input  imu_unpk_pkg::res_t res1_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output imu_unpk_pkg::res_t res_o
);

  imu_unpk_pkg::res_t mem_q [imu_unpk_pkg::OutDepth];
  logic [imu_unpk_pkg::OutPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [imu_unpk_pkg::OutCntW-1:0] cnt_q, cnt_d;
  logic [imu_unpk_pkg::OutCntW-1:0] n_in;
  logic pop;

  // room for the two results one item can cause
  assign room_o      = (cnt_q <= imu_unpk_pkg::OutCntW'(imu_unpk_pkg::OutDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign res_o       = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  assign n_in        = push_en_i ? imu_unpk_pkg::OutCntW'(push_n_i) : '0;

  always_comb begin
    wr_d  = wr_q + imu_unpk_pkg::OutPtrW'(n_in);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + n_in - {{(imu_unpk_pkg::OutCntW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_in != '0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (n_in == imu_unpk_pkg::OutCntW'(2)) begin
      mem_q[wr_q + 1'b1] <= res1_i;
    end
  end

  `ASSERT_NEVER(a_cnt_max, cnt_q > imu_unpk_pkg::OutCntW'(imu_unpk_pkg::OutDepth), "result queue count over depth")
  `ASSERT_CLK(a_no_ovf, (n_in != '0) |-> room_o, "results pushed without room")

endmodule

// ----- hdl/imu_sensor_frame_unpacker.sv -----
// Channel   | Handshake                | Payload
// ----------+--------------------------+--------------------------------------------
// input     | in_valid_i / in_ready_o  | cmd_i, rx_byte_i, frame_end_i
// result    | out_valid_o / out_ready_i| kind_o, quantity_o, value_bits_o, ...
// config    | psel/penable/pwrite      | paddr, pwdata, prdata (pready tied high)
//
// One item per cycle sustained while the result queue has room; the back end
// handles each popped item combinationally, and results are registered in the
// output queue. An item causing two results (last element plus frame status)
// pushes both together; the queue drains one per cycle while out_ready_i is high.
// The back end stalls while the 4-entry result queue has fewer than two free
// entries; the 2-entry input queue then fills and in_ready_o drops.
// Reset clears queues, frame state, link counter and reply flag; config goes to
// its defaults.
module imu_sensor_frame_unpacker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           frame_end_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [4:0]                     quantity_o,
  output logic [31:0]                    value_bits_o,
  output logic [1:0]                     value_format_o,
  output logic [2:0]                     decimal_places_o,
  output logic [2:0]                     frame_status_o,
  output logic                           reply_flag_o,
  output logic                           last_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [imu_unpk_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  imu_unpk_pkg::cfg_t  cfg_q, cfg_d;
  imu_unpk_pkg::item_t item;
  imu_unpk_pkg::res_t  res0, res1, res_out;
  imu_unpk_pkg::reg_idx_e ridx;
  logic       item_valid, item_pop, room;
  logic [1:0] res_n;
  logic       wr_en;

  assign pready = 1'b1;
  assign ridx   = imu_unpk_pkg::reg_idx_e'(paddr[imu_unpk_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (ridx)
        imu_unpk_pkg::REG_DEV_ID:    cfg_d.dev_id    = pwdata[15:0];
        imu_unpk_pkg::REG_DECODE_EN: cfg_d.decode_en = pwdata[0];
        imu_unpk_pkg::REG_PREC32:    cfg_d.prec32    = pwdata[0];
        imu_unpk_pkg::REG_RADIANS:   cfg_d.radians   = pwdata[0];
        imu_unpk_pkg::REG_MASK:      cfg_d.mask      = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      imu_unpk_pkg::REG_DEV_ID:    prdata = {16'h0, cfg_q.dev_id};
      imu_unpk_pkg::REG_DECODE_EN: prdata = {31'h0, cfg_q.decode_en};
      imu_unpk_pkg::REG_PREC32:    prdata = {31'h0, cfg_q.prec32};
      imu_unpk_pkg::REG_RADIANS:   prdata = {31'h0, cfg_q.radians};
      imu_unpk_pkg::REG_MASK:      prdata = {22'h0, cfg_q.mask};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_id    <= 16'd1;
      cfg_q.decode_en <= 1'b0;
      cfg_q.prec32    <= 1'b1;
      cfg_q.radians   <= 1'b1;
      cfg_q.mask      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  imu_unpk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .rx_byte_i   (rx_byte_i),
    .frame_end_i (frame_end_i),
    .item_valid_o(item_valid),
    .item_pop_i  (item_pop),
    .item_o      (item)
  );

  imu_unpk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(item_valid),
    .item_i      (item),
    .room_i      (room),
    .item_pop_o  (item_pop),
    .res_n_o     (res_n),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  imu_unpk_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_en_i  (item_pop),
    .push_n_i   (res_n),
    .res0_i     (res0),
    .res1_i     (res1),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign kind_o           = res_out.kind;
  assign quantity_o       = res_out.quantity;
  assign value_bits_o     = res_out.value_bits;
  assign value_format_o   = res_out.value_format;
  assign decimal_places_o = res_out.decimal_places;
  assign frame_status_o   = res_out.frame_status;
  assign reply_flag_o     = res_out.reply_flag;
  assign last_o           = res_out.last;

endmodule
